>>> src/tunnel_rx_header_replay_check_assert.svh
// Assertion macros for the replay check RTL; trhrc_back is the only user.
// Depends on nothing; files that assert include it by its bare name.
`ifndef TUNNEL_RX_HEADER_REPLAY_CHECK_ASSERT_SVH
`define TUNNEL_RX_HEADER_REPLAY_CHECK_ASSERT_SVH

// Clocked assertion, disabled while the active-low reset is asserted.
`define TRHRC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Property that must never hold.
`define TRHRC_ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

>>> src/trhrc_pkg.sv
// Package for the tunnel receive header and replay check.
// Holds widths, codes and the queue item type; depends on nothing.
`default_nettype none

package trhrc_pkg;

  // Field widths.
  localparam int unsigned PacketLenW = 16;
  localparam int unsigned WordW      = 32;
  localparam int unsigned CounterW   = 64;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned HalfW      = 16;
  localparam int unsigned StatusW    = 3;
  localparam int unsigned PrefixW    = 11;
  localparam int unsigned CapacityW  = 16;
  localparam int unsigned NeedW      = 12;

  // Configuration port.
  localparam int unsigned CfgIndexW = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam logic [CfgIndexW-1:0] RegSessionReady = 3'd0;
  localparam logic [CfgIndexW-1:0] RegPrefixLength = 3'd1;
  localparam logic [CfgIndexW-1:0] RegHeaderLowest = 3'd2;
  localparam logic [CfgIndexW-1:0] RegHeaderHighest = 3'd3;
  localparam logic [CfgIndexW-1:0] RegPeerIndex = 3'd4;
  localparam logic [CfgIndexW-1:0] RegOutCapacity = 3'd5;

  // Anti-replay window and framing.
  localparam int unsigned WindowBits        = 64;
  localparam int unsigned WinIdxW           = $clog2(WindowBits);
  localparam int unsigned TransportOverhead = 32;
  localparam int unsigned Ipv4MinHdr        = 20;
  localparam int unsigned Ipv6Hdr           = 40;
  localparam int unsigned Ipv4MinPlain      = 4;
  localparam int unsigned Ipv6MinPlain      = 6;
  localparam logic [3:0]  IpVer4            = 4'd4;
  localparam logic [3:0]  IpVer6            = 4'd6;

  // Queue between the classifier and the window stage.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  typedef enum logic [StatusW-1:0] {
    StOk     = 3'd0,
    StFormat = 3'd1,
    StReplay = 3'd2,
    StSpace  = 3'd3,
    StAuth   = 3'd4
  } status_e;

  // One classified packet as it waits for the window stage.
  typedef struct packed {
    logic                fmt_err;
    logic                space_err;
    logic                auth_err;
    logic [CounterW-1:0] counter;
    logic [HalfW-1:0]    inner_len;
  } item_t;

endpackage

`default_nettype wire

>>> src/trhrc_front.sv
// Front classifier: configuration registers, format, space and auth checks,
// and inner IP length trimming. Depends on trhrc_pkg.
`default_nettype none

module trhrc_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [trhrc_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  logic [trhrc_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic [trhrc_pkg::PacketLenW-1:0]   packet_length_i,
  input  logic [trhrc_pkg::WordW-1:0]        header_word_i,
  input  logic [trhrc_pkg::WordW-1:0]        index_word_i,
  input  logic [trhrc_pkg::CounterW-1:0]     packet_counter_i,
  input  logic                               auth_ok_i,
  input  logic [trhrc_pkg::ByteW-1:0]        inner_first_byte_i,
  input  logic [trhrc_pkg::HalfW-1:0]        inner_bytes_two_three_i,
  input  logic [trhrc_pkg::HalfW-1:0]        inner_bytes_four_five_i,
  output trhrc_pkg::item_t                   item_o
);
  import trhrc_pkg::*;

  logic                 session_q;
  logic [PrefixW-1:0]   prefix_q;
  logic [WordW-1:0]     hdr_lo_q;
  logic [WordW-1:0]     hdr_hi_q;
  logic [WordW-1:0]     peer_q;
  logic [CapacityW-1:0] capacity_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      session_q  <= 1'b0;
      prefix_q   <= '0;
      hdr_lo_q   <= '0;
      hdr_hi_q   <= '1;
      peer_q     <= '0;
      capacity_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        RegSessionReady:  session_q  <= cfg_wdata_i[0];
        RegPrefixLength:  prefix_q   <= cfg_wdata_i[PrefixW-1:0];
        RegHeaderLowest:  hdr_lo_q   <= cfg_wdata_i[WordW-1:0];
        RegHeaderHighest: hdr_hi_q   <= cfg_wdata_i[WordW-1:0];
        RegPeerIndex:     peer_q     <= cfg_wdata_i[WordW-1:0];
        RegOutCapacity:   capacity_q <= cfg_wdata_i[CapacityW-1:0];
        default: ;
      endcase
    end
  end

  logic [NeedW-1:0]      need;
  logic [PacketLenW-1:0] plain;
  logic                  len_ok;
  logic                  hdr_ok;
  logic [HalfW:0]        v6_len;
  logic [HalfW-1:0]      trimmed;

  always_comb begin
    need   = {1'b0, prefix_q} + NeedW'(TransportOverhead);
    len_ok = packet_length_i >= PacketLenW'(need);
    plain  = packet_length_i - PacketLenW'(need);
    hdr_ok = (header_word_i >= hdr_lo_q) && (header_word_i <= hdr_hi_q);
    v6_len = (HalfW + 1)'(Ipv6Hdr) + {1'b0, inner_bytes_four_five_i};

    // Version 4 and 6 lengths are trusted only when they fit in the plaintext.
    trimmed = plain;
    if (inner_first_byte_i[7:4] == IpVer4 && plain >= PacketLenW'(Ipv4MinPlain)) begin
      if (inner_bytes_two_three_i >= HalfW'(Ipv4MinHdr) && inner_bytes_two_three_i <= plain) begin
        trimmed = inner_bytes_two_three_i;
      end
    end else if (inner_first_byte_i[7:4] == IpVer6 &&
                 plain >= PacketLenW'(Ipv6MinPlain)) begin
      if (v6_len <= {1'b0, plain}) begin
        trimmed = v6_len[HalfW-1:0];
      end
    end

    item_o.fmt_err   = !session_q || !len_ok || !hdr_ok || (index_word_i != peer_q);
    item_o.space_err = plain > capacity_q;
    item_o.auth_err  = !auth_ok_i;
    item_o.counter   = packet_counter_i;
    item_o.inner_len = trimmed;
  end

endmodule

`default_nettype wire

>>> src/trhrc_queue.sv
// Short register queue between the classifier and the window stage.
// Depends on trhrc_pkg for its depth and item type.
`default_nettype none

module trhrc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  trhrc_pkg::item_t push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output trhrc_pkg::item_t pop_data_o
);
  import trhrc_pkg::*;

  item_t                entry_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] count_q;
  logic                 push, pop;

  assign push_ready_o = count_q != QueueCntW'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> src/trhrc_back.sv
// Window stage: anti-replay bitmap, highest counter, final status and the
// output register. Depends on trhrc_pkg and the assertion macro header.
`default_nettype none
`include "tunnel_rx_header_replay_check_assert.svh"

module trhrc_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           pop_valid_i,
  output logic                           pop_ready_o,
  input  trhrc_pkg::item_t               pop_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [trhrc_pkg::StatusW-1:0]  status_o,
  output logic [trhrc_pkg::HalfW-1:0]    inner_length_o
);
  import trhrc_pkg::*;

  localparam logic [WindowBits-1:0] WinSingle = {{(WindowBits - 1){1'b0}}, 1'b1};

  logic [WindowBits-1:0] win_q, win_d;
  logic [CounterW-1:0]   high_q, high_d;
  logic                  seen_q, seen_d;
  logic                  out_valid_q;
  status_e               status_q, status_d;
  logic [HalfW-1:0]      len_q, len_d;

  logic                  pop;
  logic                  newer;
  logic [CounterW-1:0]   diff_up, diff_dn;
  logic                  far_up, far_dn;
  logic [WinIdxW-1:0]    idx_up, idx_dn;
  logic                  replay;
  logic [WindowBits-1:0] win_cand;

  assign pop_ready_o = !out_valid_q || out_ready_i;
  assign pop         = pop_valid_i && pop_ready_o;

  always_comb begin
    newer   = seen_q && (pop_data_i.counter > high_q);
    diff_up = pop_data_i.counter - high_q;
    diff_dn = high_q - pop_data_i.counter;
    far_up  = diff_up >= CounterW'(WindowBits);
    far_dn  = diff_dn >= CounterW'(WindowBits);
    idx_up  = diff_up[WinIdxW-1:0];
    idx_dn  = diff_dn[WinIdxW-1:0];

    replay   = 1'b0;
    win_cand = win_q;
    if (!seen_q) begin
      win_cand = WinSingle;
    end else if (newer) begin
      win_cand = far_up ? WinSingle : ((win_q << idx_up) | WinSingle);
    end else if (far_dn || win_q[idx_dn]) begin
      replay = 1'b1;
    end else begin
      win_cand = win_q | (WinSingle << idx_dn);
    end

    if (pop_data_i.fmt_err) begin
      status_d = StFormat;
    end else if (replay) begin
      status_d = StReplay;
    end else if (pop_data_i.space_err) begin
      status_d = StSpace;
    end else if (pop_data_i.auth_err) begin
      status_d = StAuth;
    end else begin
      status_d = StOk;
    end

    // The window moves even on space or auth failure; the counter only on success.
    win_d  = (pop_data_i.fmt_err || replay) ? win_q : win_cand;
    high_d = high_q;
    seen_d = seen_q;
    if (status_d == StOk) begin
      seen_d = 1'b1;
      if (!seen_q || newer) begin
        high_d = pop_data_i.counter;
      end
    end
    len_d = (status_d == StOk) ? pop_data_i.inner_len : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= '0;
      high_q      <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        win_q  <= win_d;
        high_q <= high_d;
        seen_q <= seen_d;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      status_q <= status_d;
      len_q    <= len_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign inner_length_o = len_q;

  `TRHRC_ASSERT(a_ok_sets_seen, clk_i, rst_ni, pop && status_d == StOk |=> seen_q,
                "accepted packet did not mark the counter as seen")
  `TRHRC_ASSERT_NEVER(a_replay_before_seen, clk_i, rst_ni,
                      pop && !seen_q && status_d == StReplay,
                      "replay reported before any counter was recorded")
  `TRHRC_ASSERT(a_seen_has_bit0, clk_i, rst_ni, seen_q |-> win_q[0],
                "window lost the bit of the highest counter")
  `TRHRC_ASSERT(a_fail_len_zero, clk_i, rst_ni,
                out_valid_q && status_q != StOk |-> len_q == '0,
                "inner length nonzero on a rejected packet")
  `TRHRC_ASSERT(a_high_grows, clk_i, rst_ni,
                $past(seen_q) && seen_q |-> high_q >= $past(high_q),
                "highest counter moved backwards")

endmodule

`default_nettype wire

>>> src/tunnel_rx_header_replay_check.sv
// Top level of the tunnel receive header and replay check.
// Instantiates trhrc_front, trhrc_queue and trhrc_back; uses trhrc_pkg.
//
// Usage:
//   The input channel (in_valid_i / in_ready_o) carries one packet descriptor
//   per item: lengths, header and index words, the 64-bit counter, the AEAD
//   verdict and the leading inner IP bytes. The output channel
//   (out_valid_o / out_ready_i) returns one item per packet: a status code
//   and the trimmed inner IP length, which is zero unless the status is ok.
//   Results come back in input order. An accepted input is written into the
//   queue and then into the output register that drives out_valid_o.
//   Throughput is one item per cycle while the receiver keeps up: the
//   window stage handles one packet each cycle unless an output stall holds
//   it, and its bitmap shift and counter compare finish within that cycle.
//   When the receiver stalls, the output register holds its item, the queue
//   absorbs up to two classified items, and then in_ready_o drops.
//   Configuration writes (cfg_we_i, cfg_index_i, cfg_wdata_i) take effect at
//   the next edge and are meant for idle periods; unknown indexes are ignored.
//   Reset clears the replay window, the highest counter, the seen flag and
//   the queue, and loads the register defaults; no clearing pass is needed.
`default_nettype none

module tunnel_rx_header_replay_check (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [trhrc_pkg::CfgIndexW-1:0]   cfg_index_i,
  input  logic [trhrc_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [trhrc_pkg::PacketLenW-1:0]  packet_length_i,
  input  logic [trhrc_pkg::WordW-1:0]       header_word_i,
  input  logic [trhrc_pkg::WordW-1:0]       index_word_i,
  input  logic [trhrc_pkg::CounterW-1:0]    packet_counter_i,
  input  logic                              auth_ok_i,
  input  logic [trhrc_pkg::ByteW-1:0]       inner_first_byte_i,
  input  logic [trhrc_pkg::HalfW-1:0]       inner_bytes_two_three_i,
  input  logic [trhrc_pkg::HalfW-1:0]       inner_bytes_four_five_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [trhrc_pkg::StatusW-1:0]     status_o,
  output logic [trhrc_pkg::HalfW-1:0]       inner_length_o
);
  import trhrc_pkg::*;

  // Classified item from the front end, before the window check.
  item_t front_item;
  item_t queue_item;
  logic  queue_valid;
  logic  back_ready;

  // The front end is stateless apart from configuration, so each item is
  // classified in the cycle it is offered and lands directly in the queue.
  trhrc_front u_front (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .cfg_we_i                (cfg_we_i),
    .cfg_index_i             (cfg_index_i),
    .cfg_wdata_i             (cfg_wdata_i),
    .packet_length_i         (packet_length_i),
    .header_word_i           (header_word_i),
    .index_word_i            (index_word_i),
    .packet_counter_i        (packet_counter_i),
    .auth_ok_i               (auth_ok_i),
    .inner_first_byte_i      (inner_first_byte_i),
    .inner_bytes_two_three_i (inner_bytes_two_three_i),
    .inner_bytes_four_five_i (inner_bytes_four_five_i),
    .item_o                  (front_item)
  );

  // The queue decouples input acceptance from output stalls.
  trhrc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (in_valid_i),
    .push_ready_o (in_ready_o),
    .push_data_i  (front_item),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (back_ready),
    .pop_data_o   (queue_item)
  );

  // The back end owns all packet-to-packet state and the output register.
  trhrc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pop_valid_i    (queue_valid),
    .pop_ready_o    (back_ready),
    .pop_data_i     (queue_item),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .inner_length_o (inner_length_o)
  );

endmodule

`default_nettype wire
